/* rtl/mi3_pkg.sv */
package mi3_pkg;

  localparam int ELEM_W    = 32;
  localparam int FRAC_W    = 16;
  localparam int THRESH_W  = 31;
  localparam int N_ELEM    = 9;
  localparam int PROD_W    = 2 * ELEM_W;           // element x element
  localparam int COF_W     = PROD_W + 1;           // signed cofactor
  localparam int MAG_W     = PROD_W;               // |cofactor|
  localparam int DET_W     = 3 * ELEM_W + 2;       // signed determinant
  localparam int PART_W    = ELEM_W + COF_W - ELEM_W + ELEM_W; // det partial product
  localparam int SHIFT_W   = 2 * FRAC_W;           // scaling of numerator
  localparam int QUO_W     = ELEM_W;
  localparam int REM_W     = MAG_W + SHIFT_W;
  localparam int DIV_W     = DET_W + QUO_W - 1;
  localparam int FRONT_LAT = 7;
  localparam int DIV_LAT   = QUO_W + 1;
  localparam int PIPE_LAT  = FRONT_LAT + DIV_LAT;

  localparam logic [ELEM_W-1:0] FIXED_ONE = ELEM_W'(1) << FRAC_W;
  localparam logic [ELEM_W-1:0] SAT_MAX   = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic [ELEM_W-1:0] SAT_MIN   = {1'b1, {(ELEM_W-1){1'b0}}};

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [COF_W-1:0]  cof_t;
  typedef logic [MAG_W-1:0]         mag_t;
  typedef logic [DET_W-1:0]         det_t;

  typedef struct packed {
    logic valid;
    logic singular;
  } tag_t;

endpackage

/* rtl/mi3_front.sv */
module mi3_front
  import mi3_pkg::*;
(
  input  logic                clk,
  input  logic                en,
  input  elem_t               m [N_ELEM],
  input  logic [THRESH_W-1:0] thresh,
  output mag_t                cof_mag [N_ELEM],
  output logic [N_ELEM-1:0]   cof_neg,
  output det_t                det_mag,
  output logic                det_neg,
  output logic                singular
);

  // stage 1: products, pa - pb gives each signed cofactor
  prod_t pa [N_ELEM];
  prod_t pb [N_ELEM];
  elem_t m1 [3];
  // stage 2
  cof_t  cof2 [N_ELEM];
  elem_t m2 [3];
  // stage 3: det partials, cofactor split into low unsigned and high signed halves
  logic signed [COF_W-1:0] plo [3];
  logic signed [COF_W-1:0] phi [3];
  cof_t  cof3 [N_ELEM];
  // stage 4
  logic signed [DET_W-1:0] term [3];
  cof_t  cof4 [N_ELEM];
  // stage 5
  logic signed [DET_W-1:0] det5;
  cof_t  cof5 [N_ELEM];
  // stage 6
  det_t  mag6;
  logic  neg6;
  mag_t  cmag6 [N_ELEM];
  logic [N_ELEM-1:0] cneg6;

  always_ff @(posedge clk) begin
    if (en) begin
      pa[0] <= m[4] * m[8];  pb[0] <= m[5] * m[7];
      pa[1] <= m[5] * m[6];  pb[1] <= m[3] * m[8];
      pa[2] <= m[3] * m[7];  pb[2] <= m[4] * m[6];
      pa[3] <= m[2] * m[7];  pb[3] <= m[1] * m[8];
      pa[4] <= m[0] * m[8];  pb[4] <= m[2] * m[6];
      pa[5] <= m[1] * m[6];  pb[5] <= m[0] * m[7];
      pa[6] <= m[1] * m[5];  pb[6] <= m[2] * m[4];
      pa[7] <= m[2] * m[3];  pb[7] <= m[0] * m[5];
      pa[8] <= m[0] * m[4];  pb[8] <= m[1] * m[3];
      for (int i = 0; i < 3; i++) m1[i] <= m[i];

      for (int j = 0; j < N_ELEM; j++) cof2[j] <= COF_W'(pa[j]) - COF_W'(pb[j]);
      m2 <= m1;

      for (int i = 0; i < 3; i++) begin
        plo[i] <= m2[i] * $signed({1'b0, cof2[i][ELEM_W-1:0]});
        phi[i] <= m2[i] * $signed(cof2[i][COF_W-1:ELEM_W]);
      end
      cof3 <= cof2;

      for (int i = 0; i < 3; i++)
        term[i] <= $signed({phi[i][COF_W-1], phi[i], {ELEM_W{1'b0}}})
                 + $signed({{(DET_W-COF_W){plo[i][COF_W-1]}}, plo[i]});
      cof4 <= cof3;

      det5 <= term[0] + term[1] + term[2];
      cof5 <= cof4;

      neg6 <= det5[DET_W-1];
      mag6 <= det5[DET_W-1] ? det_t'(-det5) : det_t'(det5);
      for (int j = 0; j < N_ELEM; j++) begin
        cneg6[j] <= cof5[j][COF_W-1];
        cmag6[j] <= cof5[j][COF_W-1] ? MAG_W'(-cof5[j]) : MAG_W'(cof5[j]);
      end

      singular <= mag6 <= {{(DET_W-THRESH_W-SHIFT_W){1'b0}}, thresh, {SHIFT_W{1'b0}}};
      det_mag  <= mag6;
      det_neg  <= neg6;
      cof_mag  <= cmag6;
      cof_neg  <= cneg6;
    end
  end

endmodule

/* rtl/mi3_div.sv */
module mi3_div
  import mi3_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  mag_t              num_mag,
  input  det_t              den_mag,
  input  logic              neg,
  output logic [ELEM_W-1:0] res,
  output logic              ovf
);

  logic [REM_W-1:0] rem_s [DIV_LAT];
  det_t             den_s [DIV_LAT];
  logic [QUO_W-1:0] quo_s [DIV_LAT];
  logic [DIV_LAT-1:0] neg_s;
  logic [DIV_LAT-1:0] big_s;   // quotient does not fit QUO_W bits

  always_ff @(posedge clk) begin
    if (en) begin
      rem_s[0] <= {num_mag, {SHIFT_W{1'b0}}};
      den_s[0] <= den_mag;
      quo_s[0] <= '0;
      neg_s[0] <= neg;
      big_s[0] <= {{(DET_W-MAG_W){1'b0}}, num_mag} >= den_mag;
    end
  end

  // one quotient bit per stage, msb first
  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    localparam int B = QUO_W - 1 - k;
    logic [DIV_W-1:0] dsh;
    logic [DIV_W-1:0] rx;
    logic [DIV_W-1:0] diff;
    logic             ge;
    logic [QUO_W-1:0] qn;

    always_comb begin
      dsh   = {{(DIV_W-DET_W){1'b0}}, den_s[k]} << B;
      rx    = {{(DIV_W-REM_W){1'b0}}, rem_s[k]};
      diff  = rx - dsh;
      ge    = rx >= dsh;
      qn    = quo_s[k];
      qn[B] = ge;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k+1] <= ge ? diff[REM_W-1:0] : rem_s[k];
        den_s[k+1] <= den_s[k];
        quo_s[k+1] <= qn;
        neg_s[k+1] <= neg_s[k];
        big_s[k+1] <= big_s[k];
      end
    end
  end

  logic [QUO_W-1:0] q;
  logic             nq;
  logic             bq;

  always_comb begin
    q  = quo_s[DIV_LAT-1];
    nq = neg_s[DIV_LAT-1];
    bq = big_s[DIV_LAT-1];
    ovf = 1'b0;
    if (!nq) begin
      if (bq || q[QUO_W-1]) begin
        ovf = 1'b1;
        res = SAT_MAX;
      end else begin
        res = q;
      end
    end else begin
      if (bq || (q[QUO_W-1] && (|q[QUO_W-2:0]))) begin
        ovf = 1'b1;
        res = SAT_MIN;
      end else begin
        res = -q;
      end
    end
  end

endmodule

/* rtl/matrix3x3_inverse_top.sv */
// 3x3 matrix inverse by the adjugate, signed Q16.16.
// Input stream s_*: one item is a whole matrix, nine elements row-major.
// Output stream m_*: the inverse, row-major, with singular and overflow flags.
// cfg_*: singular threshold write, unsigned Q15.16 magnitude; always ready.
// A matrix whose |det| is at or below the threshold returns the identity with
// singular set. Other results are truncated toward zero and saturated, with
// overflow set when any element saturates.
// Pipeline: 7 cofactor and determinant stages, 33 divider stages, output register.
// Throughput: one matrix per cycle while the receiver does not stall; nine
// pipelined restoring dividers, one quotient bit per stage, run side by side.
// When the receiver stalls the whole pipeline holds, s_tready drops and no
// item is lost or repeated; s_tready stays high while the output register
// is empty or being taken.
// Reset clears all valid bits and sets the threshold to 2^-16 (raw value 1).
module matrix3x3_inverse_top
  import mi3_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [N_ELEM*ELEM_W-1:0]   s_tdata,   // elem_r0c0 .. elem_r2c2, lowest first
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [N_ELEM*ELEM_W-1:0]   m_tdata,   // inv_r0c0 .. inv_r2c2, lowest first
  output logic [1:0]                 m_tuser,   // bit 0 singular, bit 1 overflow
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [THRESH_W-1:0]        cfg_data
);

  logic [THRESH_W-1:0] thresh;
  logic                en;
  tag_t                tag [PIPE_LAT+1];

  elem_t               m [N_ELEM];
  mag_t                cof_mag [N_ELEM];
  logic [N_ELEM-1:0]   cof_neg;
  det_t                det_mag;
  logic                det_neg;
  logic                singular;
  logic [ELEM_W-1:0]   res [N_ELEM];
  logic [N_ELEM-1:0]   ovf;

  assign cfg_ready = 1'b1;
  assign en        = !m_tvalid || m_tready;
  assign s_tready  = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= THRESH_W'(1);
    end else if (cfg_valid) begin
      thresh <= cfg_data;
    end
  end

  for (genvar i = 0; i < N_ELEM; i++) begin : g_in
    assign m[i] = s_tdata[i*ELEM_W +: ELEM_W];
  end

  mi3_front u_front (
    .clk      (clk),
    .en       (en),
    .m        (m),
    .thresh   (thresh),
    .cof_mag  (cof_mag),
    .cof_neg  (cof_neg),
    .det_mag  (det_mag),
    .det_neg  (det_neg),
    .singular (singular)
  );

  // result (r,k) is cofactor (k,r) over det
  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar k = 0; k < 3; k++) begin : g_col
      mi3_div u_div (
        .clk     (clk),
        .en      (en),
        .num_mag (cof_mag[k*3+r]),
        .den_mag (det_mag),
        .neg     (cof_neg[k*3+r] ^ det_neg),
        .res     (res[r*3+k]),
        .ovf     (ovf[r*3+k])
      );
    end
  end

  // valid and singular travel beside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= PIPE_LAT; i++) tag[i] <= '0;
    end else if (en) begin
      tag[0].valid <= s_tvalid;
      tag[0].singular <= 1'b0;
      for (int i = 1; i <= PIPE_LAT; i++)
        if (i != FRONT_LAT) tag[i] <= tag[i-1];
      tag[FRONT_LAT].valid <= tag[FRONT_LAT-1].valid;
      tag[FRONT_LAT].singular <= singular;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N_ELEM; i++) begin
        if (tag[PIPE_LAT-1].singular)
          m_tdata[i*ELEM_W +: ELEM_W] <= (i % 4 == 0) ? FIXED_ONE : '0;
        else
          m_tdata[i*ELEM_W +: ELEM_W] <= res[i];
      end
      m_tuser <= {!tag[PIPE_LAT-1].singular && (|ovf), tag[PIPE_LAT-1].singular};
    end
  end

  assign m_tvalid = tag[PIPE_LAT].valid;

`ifndef ASSERT_OFF
  a_sing_no_ovf: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> !m_tuser[1])
    else $error("singular result flagged overflow");

  a_sing_ident: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[ELEM_W-1:0] == FIXED_ONE
      && m_tdata[2*ELEM_W-1:ELEM_W] == '0)
    else $error("singular result is not identity");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");
`endif

endmodule
